// ----- sv/bcd_pkg.sv -----
// Shared constants and types for the bin coverage dispersion block.
`timescale 1ns / 1ps

package bcd_pkg;

  // Default geometry
  localparam int BINS_DEF       = 50;
  localparam int DIMS_DEF       = 4;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int SPREAD_W   = 16;
  localparam int NDIM_MAX   = 4;
  localparam int DIMS_USE_W = 3;

  // Configuration register map: index 2d is the low bound, 2d+1 the high bound
  localparam int CFG_IDX_W   = 4;
  localparam int NREGS       = 8;
  localparam int REG_HIGH_SEL = 1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_div_sts_t;

endpackage

// ----- sv/bin_coverage_dispersion.sv -----
// Top level of the bin coverage dispersion block: box binning, quintile selection, output.
`timescale 1ns / 1ps

// Each accepted box is binned one dimension after another. For a dimension the
// box fits in, the divider runs twice (low and high bin number), a range check
// and bookkeeping follow, and each covered bin is read and then written back
// with a saturating increment of the counter memory; a dimension the box
// misses, or any dimension of a box that is not present, gets only the range
// check and bookkeeping. in_tready is low meanwhile.
// A box with tlast then runs the result pass: each reported dimension walks
// the counter memory once per bin to rank it, through the single read port of
// the counter memory. Counters are cleared at once after a result through
// per-entry valid flags, so there is no clearing pass after reset. The result
// is held in an output register, so the next box may be taken while it waits.
module bin_coverage_dispersion
  import bcd_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int DIMS       = DIMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // box_low_d0, box_high_d0, ..., box_low_d3, box_high_d3, dims_in_use, zero pad
  input  logic [263:0]         in_tdata,
  // box_present
  input  logic [0:0]           in_tuser,
  input  logic                 in_tlast,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // spread_d0, spread_d1, spread_d2, spread_d3
  output logic [63:0]          out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int QB    = $clog2(BINS + 1);
  localparam int NENT  = DIMS * BINS;
  localparam int AW    = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int DIW   = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int RANK1 = BINS / 5;
  localparam int RANK2 = (4 * BINS) / 5;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_WLO   = 4'd2;
  localparam logic [3:0] S_WHI   = 4'd3;
  localparam logic [3:0] S_INC   = 4'd4;
  localparam logic [3:0] S_INCW  = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_SBEG  = 4'd7;
  localparam logic [3:0] S_SI    = 4'd8;
  localparam logic [3:0] S_SIW   = 4'd9;
  localparam logic [3:0] S_SJ    = 4'd10;
  localparam logic [3:0] S_SJW   = 4'd11;
  localparam logic [3:0] S_SCHK  = 4'd12;
  localparam logic [3:0] S_SDONE = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Configuration registers
  logic signed [COORD_W-1:0] ext_low_r  [NDIM_MAX];
  logic signed [COORD_W-1:0] ext_high_r [NDIM_MAX];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NDIM_MAX; n++) begin
        ext_low_r[n]  <= '0;
        ext_high_r[n] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NREGS))) begin
      if (cfg_index[0] == 1'(REG_HIGH_SEL)) begin
        ext_high_r[cfg_index[2:1]] <= cfg_data;
      end else begin
        ext_low_r[cfg_index[2:1]] <= cfg_data;
      end
    end
  end

  // Sequencer state and working registers
  logic [3:0]                state_r;
  logic [DIW-1:0]            d_r;
  logic signed [COORD_W-1:0] box_lo_r [NDIM_MAX];
  logic signed [COORD_W-1:0] box_hi_r [NDIM_MAX];
  logic                      pres_r;
  logic                      last_r;
  logic [DIMS_USE_W-1:0]     used_r;
  logic [COORD_W-1:0]        width_r;
  logic [COORD_W-1:0]        offhi_r;
  logic [QB-1:0]             blo_r;
  logic [QB-1:0]             bhi_r;
  logic [QB-1:0]             k_r;
  logic [QB-1:0]             i_r;
  logic [QB-1:0]             lt_r;
  logic [QB-1:0]             le_r;
  logic [COUNT_BITS-1:0]     piv_r;
  logic [COUNT_BITS-1:0]     v1_r;
  logic [COUNT_BITS-1:0]     v2_r;
  logic                      f1_r;
  logic                      f2_r;
  logic [SPREAD_W-1:0]       spread_r [NDIM_MAX];
  logic [63:0]               out_data_r;
  logic                      out_valid_r;

  // Counter memory with per-entry valid flags (invalid reads as zero)
  logic [COUNT_BITS-1:0] mem [NENT];
  logic [NENT-1:0]       vld_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  vld_q_r;
  logic [COUNT_BITS-1:0] rd_val;
  logic [AW-1:0]         mem_addr;
  logic                  mem_re;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] mem_wd;

  // Current dimension view
  logic [1:0]                di;
  logic signed [COORD_W-1:0] el, eh, lo, hi;
  logic                      wpos;
  logic                      box_ok;

  assign di     = 2'(d_r);
  assign el     = ext_low_r[di];
  assign eh     = ext_high_r[di];
  assign lo     = box_lo_r[di];
  assign hi     = box_hi_r[di];
  assign wpos   = (eh > el);
  assign box_ok = wpos && (lo >= el) && (lo <= eh) && (hi >= el) && (hi <= eh);

  // Divider hookup
  logic               div_start;
  logic [COORD_W-1:0] div_off;
  logic [COORD_W-1:0] div_width;
  bcd_div_sts_t       div_sts;
  logic [QB-1:0]      div_q;
  logic [QB-1:0]      bhi_clip;

  assign div_start = ((state_r == S_CHK) && pres_r && box_ok) ||
                     ((state_r == S_WLO) && div_sts.done);
  assign div_off   = (state_r == S_CHK) ? COORD_W'(lo - el) : offhi_r;
  assign div_width = (state_r == S_CHK) ? COORD_W'(eh - el) : width_r;
  assign bhi_clip  = (div_q >= QB'(BINS)) ? QB'(BINS - 1) : div_q;

  bcd_div #(
    .BINS (BINS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .off   (div_off),
    .width (div_width),
    .sts   (div_sts),
    .quot  (div_q)
  );

  // Memory addressing: k during binning, i for the pivot read, k as the sweep index
  logic [QB-1:0] bin_sel;
  assign bin_sel  = (state_r == S_SI) ? i_r : k_r;
  assign mem_addr = AW'(AW'(d_r) * AW'(BINS) + AW'(bin_sel));
  assign mem_re   = (state_r == S_INC) || (state_r == S_SI) || (state_r == S_SJ);
  assign mem_we   = (state_r == S_INCW);
  assign rd_val   = vld_q_r ? mem_q_r : '0;
  assign mem_wd   = (rd_val == '1) ? rd_val : rd_val + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
      vld_q_r <= vld_r[mem_addr];
    end
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
  end

  // Spread of the current dimension, saturated to the field width
  logic [COUNT_BITS-1:0] diff;
  logic [31:0]           diff32;
  assign diff   = v2_r - v1_r;
  assign diff32 = 32'(diff);

  logic result_dim;
  assign result_dim = (DIMS_USE_W'(d_r) < used_r) && wpos;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[mem_addr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int n = 0; n < NDIM_MAX; n++) begin
              box_lo_r[n] <= in_tdata[64*n +: COORD_W];
              box_hi_r[n] <= in_tdata[64*n+32 +: COORD_W];
            end
            used_r  <= in_tdata[256 +: DIMS_USE_W];
            pres_r  <= in_tuser[0];
            last_r  <= in_tlast;
            d_r     <= '0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          width_r <= COORD_W'(eh - el);
          offhi_r <= COORD_W'(hi - el);
          state_r <= (pres_r && box_ok) ? S_WLO : S_NEXT;
        end
        S_WLO: begin
          if (div_sts.done) begin
            blo_r   <= div_q;
            state_r <= S_WHI;
          end
        end
        S_WHI: begin
          if (div_sts.done) begin
            bhi_r <= bhi_clip;
            k_r   <= blo_r;
            state_r <= (blo_r <= bhi_clip) ? S_INC : S_NEXT;
          end
        end
        S_INC: state_r <= S_INCW;
        S_INCW: begin
          if (k_r == bhi_r) begin
            state_r <= S_NEXT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_INC;
          end
        end
        S_NEXT: begin
          if (d_r == DIW'(DIMS - 1)) begin
            d_r <= '0;
            for (int n = 0; n < NDIM_MAX; n++) begin
              spread_r[n] <= '0;
            end
            state_r <= last_r ? S_SBEG : S_IDLE;
          end else begin
            d_r     <= d_r + 1'b1;
            state_r <= S_CHK;
          end
        end
        S_SBEG: begin
          f1_r <= 1'b0;
          f2_r <= 1'b0;
          i_r  <= '0;
          if (result_dim) begin
            state_r <= S_SI;
          end else if (d_r == DIW'(DIMS - 1)) begin
            state_r <= S_OUT;
          end else begin
            d_r <= d_r + 1'b1;
          end
        end
        S_SI: state_r <= S_SIW;
        S_SIW: begin
          piv_r   <= rd_val;
          k_r     <= '0;
          lt_r    <= '0;
          le_r    <= '0;
          state_r <= S_SJ;
        end
        S_SJ: state_r <= S_SJW;
        S_SJW: begin
          if (rd_val < piv_r) begin
            lt_r <= lt_r + 1'b1;
          end
          if (rd_val <= piv_r) begin
            le_r <= le_r + 1'b1;
          end
          if (k_r == QB'(BINS - 1)) begin
            state_r <= S_SCHK;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SJ;
          end
        end
        S_SCHK: begin
          // Pivot holds sorted rank r when less-count <= r < less-or-equal-count
          if ((lt_r <= QB'(RANK1)) && (QB'(RANK1) < le_r)) begin
            v1_r <= piv_r;
            f1_r <= 1'b1;
          end
          if ((lt_r <= QB'(RANK2)) && (QB'(RANK2) < le_r)) begin
            v2_r <= piv_r;
            f2_r <= 1'b1;
          end
          if (i_r == QB'(BINS - 1)) begin
            state_r <= S_SDONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SI;
          end
        end
        S_SDONE: begin
          spread_r[di] <= (diff32 > 32'h0000_FFFF) ? 16'hFFFF : diff32[SPREAD_W-1:0];
          if (d_r == DIW'(DIMS - 1)) begin
            state_r <= S_OUT;
          end else begin
            d_r     <= d_r + 1'b1;
            state_r <= S_SBEG;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {spread_r[3], spread_r[2], spread_r[1], spread_r[0]};
            out_valid_r <= 1'b1;
            vld_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The divider is only started while it is free
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // Divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_WLO || state_r == S_WHI))
    else $error("unexpected divider result");

  // A bin number never exceeds BINS
  assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (div_q <= QB'(BINS)))
    else $error("bin number out of range");

  // Increments stay inside the covered range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INCW) |-> (k_r <= bhi_r && k_r >= blo_r))
    else $error("bin increment outside box range");

  // Both quintile ranks are found by the end of a dimension's ranking pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SDONE) |-> (f1_r && f2_r))
    else $error("quintile rank not found");

endmodule

// ----- sv/bcd_div.sv -----
// Iterative bin-number divider: floor(BINS * off / width), one quotient bit per cycle.
`timescale 1ns / 1ps

module bcd_div
  import bcd_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [COORD_W-1:0]           off,
  input  logic [COORD_W-1:0]           width,
  output bcd_div_sts_t                 sts,
  output logic [$clog2(BINS+1)-1:0]    quot
);

  localparam int QB    = $clog2(BINS + 1);
  localparam int NUM_W = COORD_W + QB;
  localparam int SW    = $clog2(QB);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]         st_r;
  logic               done_r;
  logic [COORD_W-1:0] off_r;
  logic [COORD_W-1:0] den_r;
  logic [NUM_W-1:0]   rem_r;
  logic [NUM_W-1:0]   dsh_r;
  logic [QB-1:0]      q_r;
  logic [SW-1:0]      step_r;
  logic               ge;

  assign ge = (rem_r >= dsh_r);

  // Multiply once, then restoring long division over QB steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            off_r <= off;
            den_r <= width;
            st_r  <= D_MUL;
          end
        end
        D_MUL: begin
          rem_r  <= NUM_W'(off_r) * NUM_W'(BINS);
          dsh_r  <= NUM_W'(den_r) << (QB - 1);
          step_r <= SW'(QB - 1);
          q_r    <= '0;
          st_r   <= D_RUN;
        end
        D_RUN: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[QB-2:0], ge};
          dsh_r <= dsh_r >> 1;
          if (step_r == '0) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign sts.busy = (st_r != D_IDLE);
  assign sts.done = done_r;
  assign quot     = q_r;

endmodule
